### src/msgp_pkg.sv
package msgp_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_SELECT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_ENABLE_MASK = 2'd1;

	localparam logic [4:0] OMNI_SELECT = 5'd16;

	// message type codes (status high nibble minus 8)
	localparam logic [2:0] TYPE_NOTE_OFF   = 3'd0;
	localparam logic [2:0] TYPE_NOTE_ON    = 3'd1;
	localparam logic [2:0] TYPE_AFTERTOUCH = 3'd2;
	localparam logic [2:0] TYPE_CONTROL    = 3'd3;
	localparam logic [2:0] TYPE_PROGRAM    = 3'd4;
	localparam logic [2:0] TYPE_PRESSURE   = 3'd5;
	localparam logic [2:0] TYPE_BEND       = 3'd6;

	typedef struct packed {
		logic [4:0] channel_select;
		logic [6:0] type_enable_mask;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] msg_type;
		logic [3:0] msg_channel;
		logic [6:0] first_data;
		logic [6:0] second_data;
		logic [1:0] data_count;
	} result_t;

	// true when the message type carries two data bytes
	function automatic logic two_data_bytes(input logic [2:0] msg_type);
		logic two;
		case (msg_type)
			TYPE_PROGRAM, TYPE_PRESSURE: two = 1'b0;
			default:                     two = 1'b1;
		endcase
		return two;
	endfunction

endpackage

### src/msgp_cfg.sv
module msgp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [msgp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [msgp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output msgp_pkg::cfg_t                  cfg
);

	logic [4:0] channel_select_q;
	logic [6:0] type_enable_mask_q;
	logic [4:0] chan_sat;

	assign cfg_ready = 1'b1;

	// values above omni saturate to omni
	assign chan_sat = (cfg_data[4:0] > msgp_pkg::OMNI_SELECT) ? msgp_pkg::OMNI_SELECT
	                                                         : cfg_data[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_select_q   <= '0;
			type_enable_mask_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				msgp_pkg::REG_CHANNEL_SELECT:   channel_select_q   <= chan_sat;
				msgp_pkg::REG_TYPE_ENABLE_MASK: type_enable_mask_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg.channel_select   = channel_select_q;
	assign cfg.type_enable_mask = type_enable_mask_q;

endmodule

### src/msgp_core.sv
module msgp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  msgp_pkg::cfg_t      cfg,
	output msgp_pkg::result_t   res
);

	logic       held_valid_q;
	logic       got_one_q;
	logic [2:0] held_type_q;
	logic [3:0] held_chan_q;
	logic       two_q;
	logic [6:0] first_q;

	logic is_system;
	logic is_status;
	logic chan_match;
	logic latch_status;
	logic take_data;
	logic complete;

	assign is_system    = (rx_byte[7:4] == 4'hF);
	assign is_status    = rx_byte[7] && !is_system;
	assign chan_match   = (cfg.channel_select == msgp_pkg::OMNI_SELECT)
	                   || (rx_byte[3:0] == cfg.channel_select[3:0]);
	assign latch_status = step && is_status && chan_match;
	assign take_data    = step && !rx_byte[7] && held_valid_q;
	// one-byte types finish on the first data byte, others on the second
	assign complete     = take_data && (got_one_q || !two_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			got_one_q    <= 1'b0;
		end else if (latch_status) begin
			held_valid_q <= 1'b1;
			got_one_q    <= 1'b0;
		end else if (take_data) begin
			got_one_q <= 1'b1;
			if (complete) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch_status) begin
			held_type_q <= rx_byte[6:4];
			held_chan_q <= rx_byte[3:0];
			two_q       <= msgp_pkg::two_data_bytes(rx_byte[6:4]);
		end
		if (take_data && !got_one_q) begin
			first_q <= rx_byte[6:0];
		end
	end

	assign res.valid       = complete && cfg.type_enable_mask[held_type_q];
	assign res.msg_type    = held_type_q;
	assign res.msg_channel = held_chan_q;
	assign res.first_data  = got_one_q ? first_q : rx_byte[6:0];
	assign res.second_data = two_q ? rx_byte[6:0] : 7'd0;
	assign res.data_count  = two_q ? 2'd2 : 2'd1;

endmodule

### src/midi_channel_message_parser.sv
// channel  dir  handshake              payload
// input    in   in_valid / in_ready    rx_byte
// result   out  out_valid / out_ready  msg_type msg_channel first_data second_data data_count
// config   in   cfg_valid / cfg_ready  cfg_index cfg_data
//
// one byte per cycle sustained while the result register drains; each byte goes through the
// input register, then the parser state and the result register update as it leaves
// all control state clears on arst_n; config registers reset to channel 0, all types masked
// a stalled result holds in the output register while one more byte waits in the input
// register; only then does in_ready drop
// cfg_ready is always high, config writes are registered straight into the config registers
module midi_channel_message_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       msg_type,
	output logic [3:0]                       msg_channel,
	output logic [6:0]                       first_data,
	output logic [6:0]                       second_data,
	output logic [1:0]                       data_count,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [msgp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [msgp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	msgp_pkg::cfg_t    cfg;
	msgp_pkg::result_t res;

	// input register
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// result register
	logic       valid_s2;
	logic [2:0] msg_type_s2;
	logic [3:0] msg_channel_s2;
	logic [6:0] first_data_s2;
	logic [6:0] second_data_s2;
	logic [1:0] data_count_s2;

	logic advance;
	logic step;

	// the result register can take a new value when empty or being drained
	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	msgp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	msgp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// input register takes a byte on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// result register, loaded only by completed and enabled messages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			msg_type_s2    <= res.msg_type;
			msg_channel_s2 <= res.msg_channel;
			first_data_s2  <= res.first_data;
			second_data_s2 <= res.second_data;
			data_count_s2  <= res.data_count;
		end
	end

	assign out_valid   = valid_s2;
	assign msg_type    = msg_type_s2;
	assign msg_channel = msg_channel_s2;
	assign first_data  = first_data_s2;
	assign second_data = second_data_s2;
	assign data_count  = data_count_s2;

	// a result never comes out of the parser without a byte being processed
	a_res_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> step)
		else $error("parser result without a processed byte");

	// a blocked input register keeps its byte
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input register lost a byte while stalled");

	// one-byte messages carry a zero second byte
	a_one_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && data_count_s2 == 2'd1) |-> (second_data_s2 == 7'd0))
		else $error("one-byte message with nonzero second data");

	// data count agrees with the message type
	a_count_type: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((data_count_s2 == 2'd1) == ((msg_type_s2 == msgp_pkg::TYPE_PROGRAM)
		|| (msg_type_s2 == msgp_pkg::TYPE_PRESSURE))))
		else $error("data count does not match message type");

endmodule

### sim/tb_midi_channel_message_parser.sv
module tb_midi_channel_message_parser;

	// no register sits at this index, a write must leave both registers alone
	localparam logic [msgp_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	// bytes from here up are system messages and never touch the parser
	localparam logic [7:0] SYS_BYTE_MIN = 8'hF0;
	// bytes per random segment, one segment per register setting
	localparam int SEGMENT_BYTES = 150;
	// idle wait after the queue empties, covering the input and result registers a result passes
	localparam int DRAIN_CYCLES = 6;
	localparam int OUT_HOLDOFF_CYCLES = 200;
	localparam int TIMEOUT_UNITS = 4000000;

	typedef struct {
		logic [2:0] msg_type;
		logic [3:0] msg_channel;
		logic [6:0] first_data;
		logic [6:0] second_data;
		logic [1:0] data_count;
	} midi_msg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] msg_type;
	logic [3:0] msg_channel;
	logic [6:0] first_data;
	logic [6:0] second_data;
	logic [1:0] data_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [msgp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [msgp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// parser image kept by the bench: registers and message assembly state
	logic [4:0] listen_ch = '0;
	logic [6:0] type_mask = '0;
	logic [7:0] held_status = '0;
	logic [1:0] need_cnt = '0;
	logic [1:0] got_cnt = '0;
	logic [6:0] first_byte = '0;

	midi_msg_t expected_msgs[$];
	int mismatch_count = 0;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holdoff_left = 0;

	midi_channel_message_parser i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.msg_type    (msg_type),
		.msg_channel (msg_channel),
		.first_data  (first_data),
		.second_data (second_data),
		.data_count  (data_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#(TIMEOUT_UNITS);
		$display("CHECK FAILED");
		$finish;
	end

	// program change and channel pressure carry one data byte, the rest two
	function automatic logic [1:0] bytes_for_type(input logic [2:0] t);
		return (t == msgp_pkg::TYPE_PROGRAM || t == msgp_pkg::TYPE_PRESSURE) ? 2'd1 : 2'd2;
	endfunction

	function automatic logic [7:0] make_status(input logic [2:0] t, input logic [3:0] ch);
		return {1'b1, t, ch};
	endfunction

	// advance the parser image by one accepted byte, queue the message it completes
	task automatic parse_byte(input logic [7:0] b);
		midi_msg_t m;
		logic [2:0] t;
		logic two;
		// system bytes are invisible to the parser
		if (b >= SYS_BYTE_MIN)
			return;
		if (b[7]) begin
			// status for the listened channel, or any in omni, latches and restarts the count
			if (listen_ch >= msgp_pkg::OMNI_SELECT || b[3:0] == listen_ch[3:0]) begin
				held_status = b;
				need_cnt = bytes_for_type(b[6:4]);
				got_cnt = 2'd0;
			end
			return;
		end
		// stray data with nothing held
		if (held_status == '0)
			return;
		if (got_cnt == 2'd0) begin
			first_byte = b[6:0];
			got_cnt = 2'd1;
			if (need_cnt > 2'd1)
				return;
		end else begin
			got_cnt = 2'd2;
		end
		// message complete: status always clears, no running status
		t = held_status[6:4];
		two = need_cnt > 2'd1;
		m.msg_type = t;
		m.msg_channel = held_status[3:0];
		m.first_data = first_byte;
		m.second_data = two ? b[6:0] : 7'd0;
		m.data_count = two ? 2'd2 : 2'd1;
		held_status = '0;
		if (type_mask[t])
			expected_msgs.push_back(m);
	endtask

	// compare one output transfer against the oldest queued message
	task automatic check_msg();
		midi_msg_t m;
		if (expected_msgs.size() == 0) begin
			$error("unexpected message: type %0d channel %0d data %0d %0d count %0d",
				msg_type, msg_channel, first_data, second_data, data_count);
			mismatch_count++;
			return;
		end
		m = expected_msgs.pop_front();
		if (msg_type !== m.msg_type) begin
			$error("msg_type: expected %0d, got %0d", m.msg_type, msg_type);
			mismatch_count++;
		end
		if (msg_channel !== m.msg_channel) begin
			$error("msg_channel: expected %0d, got %0d", m.msg_channel, msg_channel);
			mismatch_count++;
		end
		if (first_data !== m.first_data) begin
			$error("first_data: expected %0d, got %0d", m.first_data, first_data);
			mismatch_count++;
		end
		if (second_data !== m.second_data) begin
			$error("second_data: expected %0d, got %0d", m.second_data, second_data);
			mismatch_count++;
		end
		if (data_count !== m.data_count) begin
			$error("data_count: expected %0d, got %0d", m.data_count, data_count);
			mismatch_count++;
		end
	endtask

	// result side: sample the transfer of the edge just passed, then pick next ready
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_ready)
				check_msg();
			// a pending hold-off wins over the random stall pattern
			if (holdoff_left > 0) begin
				out_ready <= 1'b0;
				holdoff_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// one byte transfer; valid only drops when a gap is taken before the next byte
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		parse_byte(b);
		bytes_sent++;
	endtask

	// stop sending, let every queued message drain and the pipe empty out
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_msgs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write transfer, mirrored into the parser image when it lands
	task automatic write_reg(input logic [msgp_pkg::CFG_INDEX_W-1:0] idx,
		input logic [msgp_pkg::CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			msgp_pkg::REG_CHANNEL_SELECT:
				listen_ch = (d[4:0] > msgp_pkg::OMNI_SELECT) ? msgp_pkg::OMNI_SELECT : d[4:0];
			msgp_pkg::REG_TYPE_ENABLE_MASK:
				type_mask = d[6:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [3:0] pick_channel();
		if (listen_ch >= msgp_pkg::OMNI_SELECT || $urandom_range(0, 4) == 0)
			return 4'($urandom_range(0, 15));
		return listen_ch[3:0];
	endfunction

	// status plus data; optionally cut short or with system bytes slipped in
	task automatic send_message(input logic [2:0] t, input logic [3:0] ch, input int n_data,
		input bit with_sys);
		send_byte(make_status(t, ch));
		for (int i = 0; i < n_data; i++) begin
			if (with_sys && $urandom_range(0, 1))
				send_byte(8'($urandom_range(SYS_BYTE_MIN, 255)));
			send_byte(8'($urandom_range(0, 127)));
		end
	endtask

	// register settings swept through the random part, extremes included
	task automatic load_setting(input int k);
		case (k)
			0: begin
				write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
				write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'd16);
				write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'h7F);
			end
			1: begin
				write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'd0);
				write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'($urandom_range(0, 255)));
			end
			2: begin
				write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'd15);
				write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'hFF);
			end
			3: begin
				// saturates to omni
				write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'd31);
				write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'($urandom_range(0, 255)));
			end
			4: begin
				// upper bits beyond the field are dropped
				write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'hE5);
				write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'h7F);
			end
			5: begin
				// everything masked, messages complete silently
				write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'd17);
				write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'h80);
			end
			6: begin
				write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'($urandom_range(0, 255)));
				write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'($urandom_range(0, 255)));
			end
			7: begin
				write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'd16);
				write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'h7F);
			end
			default: begin
				write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'($urandom_range(0, 15)));
				write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'h7F);
			end
		endcase
	endtask

	// register defaults: channel 0 with every type masked, so nothing comes out
	task automatic test_masked_after_reset();
		send_message(msgp_pkg::TYPE_NOTE_ON, 4'd0, 2, 1'b0);
		settle();
	endtask

	// hand-picked bytes: field extremes, every type, and the odd cases
	task automatic test_directed_cases();
		write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'h7F);
		// note off with all-zero data
		send_byte(make_status(msgp_pkg::TYPE_NOTE_OFF, 4'd0));
		send_byte(8'h00);
		send_byte(8'h00);
		// pitch bend with all-ones data
		send_byte(make_status(msgp_pkg::TYPE_BEND, 4'd0));
		send_byte(8'h7F);
		send_byte(8'h7F);
		// program change completes on one data byte
		send_byte(make_status(msgp_pkg::TYPE_PROGRAM, 4'd0));
		send_byte(8'h55);
		send_byte(make_status(msgp_pkg::TYPE_PRESSURE, 4'd0));
		send_byte(8'h2A);
		// system real-time byte between data bytes changes nothing
		send_byte(make_status(msgp_pkg::TYPE_AFTERTOUCH, 4'd0));
		send_byte(8'h11);
		send_byte(8'hF8);
		send_byte(8'h22);
		// stray data, status already cleared
		send_byte(8'h33);
		// status for another channel leaves the held one in place
		send_byte(make_status(msgp_pkg::TYPE_CONTROL, 4'd0));
		send_byte(8'h01);
		send_byte(make_status(msgp_pkg::TYPE_CONTROL, 4'd5));
		send_byte(8'h02);
		// new status mid-message drops the partial note on
		send_byte(make_status(msgp_pkg::TYPE_NOTE_ON, 4'd0));
		send_byte(8'h10);
		send_byte(make_status(msgp_pkg::TYPE_CONTROL, 4'd0));
		send_byte(8'h07);
		send_byte(8'h64);
		settle();
	endtask

	// mostly well-formed messages with random content, the rest noise and broken ones
	task automatic test_random_traffic(input int s_pct, input int r_pct, input int first_seg);
		int target;
		int r;
		logic [2:0] t;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int k = first_seg; k < first_seg + 3; k++) begin
			load_setting(k);
			target = bytes_sent + SEGMENT_BYTES;
			while (bytes_sent < target) begin
				r = $urandom_range(0, 99);
				t = 3'($urandom_range(0, 6));
				if (r < 75)
					send_message(t, pick_channel(), int'(bytes_for_type(t)),
						$urandom_range(0, 4) == 0);
				else if (r < 82)
					send_byte(8'($urandom_range(SYS_BYTE_MIN, 255)));
				else if (r < 88)
					send_byte(8'($urandom_range(0, 127)));
				else if (r < 94)
					send_message(t, 4'($urandom_range(0, 15)), int'(bytes_for_type(t)),
						1'b0);
				else
					send_message(t, pick_channel(), int'(bytes_for_type(t)) - 1, 1'b0);
			end
			settle();
		end
	endtask

	// receiver stalls for a long stretch while note-ons keep coming, input must back up
	task automatic test_output_holdoff();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(msgp_pkg::REG_CHANNEL_SELECT, 8'd16);
		write_reg(msgp_pkg::REG_TYPE_ENABLE_MASK, 8'h7F);
		holdoff_left = OUT_HOLDOFF_CYCLES;
		for (int i = 0; i < 40; i++)
			send_message(msgp_pkg::TYPE_NOTE_ON, 4'($urandom_range(0, 15)), 2, 1'b0);
		settle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_masked_after_reset();
		test_directed_cases();
		test_random_traffic(35, 67, 0);
		test_output_holdoff();
		test_random_traffic(67, 35, 3);
		test_random_traffic(0, 0, 6);
		if (mismatch_count == 0 && expected_msgs.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### midi_channel_message_parser.f
src/msgp_pkg.sv
src/msgp_cfg.sv
src/msgp_core.sv
src/midi_channel_message_parser.sv
sim/tb_midi_channel_message_parser.sv
